// ----- sv/dsfa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsfa_pkg: shared types and constants of the spring force accumulator
// Holds the sequencer states and the default parameter values.
// ----------------------------------------------------------------------------
package dsfa_pkg;

    localparam int FRAC_BITS_DEF   = 16;
    localparam int VALUE_WIDTH_DEF = 32;

    // Reset value of the damping register, about 0.01 in unsigned Q0.16
    localparam logic [15:0] DAMPING_RESET = 16'd655;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,
        ST_SQ_ACC,
        ST_ROOT,
        ST_DIFF,
        ST_MUL_DIFF,
        ST_DIV,
        ST_MUL_K,
        ST_MUL_DAMP,
        ST_ACC,
        ST_EMIT
    } t_state;

endpackage

// ----- sv/damped_spring_force_accumulator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// damped_spring_force_accumulator: summed damped Hooke force over connections
// Takes one spring connection per request, adds its force into saturating
// accumulators and sends the totals on the request marked last.
// ----------------------------------------------------------------------------
// A request runs these steps in order: accept, the three squares and their
// sum, the bit-by-bit square root, the length difference, then per axis a
// multiply, the bit-by-bit divide, two multiplies and an accumulate, plus the
// hand-off of the totals to the output register on the last request.
// A zero length skips the divide and its two multiplies. The sequencer shares
// the single 32x32 multiplier, and the single 36-bit subtractor between the
// root and the three divisions. Input tready is high only while the sequencer
// is idle; a pending result holds off the next request only when a last
// request has new totals to emit. The damping register is always ready; write
// it only while the block is idle.
module damped_spring_force_accumulator #(
    parameter int FRAC_BITS   = dsfa_pkg::FRAC_BITS_DEF,
    parameter int VALUE_WIDTH = dsfa_pkg::VALUE_WIDTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // tdata: rel_pos_x[31:0], rel_pos_y[63:32], rel_pos_z[95:64],
    //        rel_vel_x[127:96], rel_vel_y[159:128], rel_vel_z[191:160],
    //        rest_length[222:192], spring_stiffness[253:223], zero pad
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [255:0] s_axis_tdata,
    input  logic         s_axis_tlast,     // last_connection
    // tdata: force_x[31:0], force_y[63:32], force_z[95:64]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [95:0]  m_axis_tdata,
    output logic         m_axis_tuser,     // zero_length_seen
    // damping_coeff register, unsigned Q0.16
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [15:0]  i_cfg_data
);

    // Force arithmetic width: spring product >> FRAC_BITS fits in 64 bits,
    // two more bits for sign and the damping subtraction.
    localparam int FW = 66;
    localparam logic signed [FW-1:0] F_HI =
        {{(FW-VALUE_WIDTH+1){1'b0}}, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic signed [FW-1:0] F_LO = ~F_HI;
    localparam logic signed [FW-1:0] O_HI = {{(FW-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [FW-1:0] O_LO = ~O_HI;

    dsfa_pkg::t_state r_state, n_state;

    // Per-connection operands, stored as magnitude and sign
    logic [31:0] r_dmag [3];
    logic        r_dneg [3];
    logic [31:0] r_vmag [3];
    logic        r_vneg [3];
    logic [30:0] r_rest;
    logic [30:0] r_k;
    logic        r_last;
    logic [1:0]  r_axis;
    logic [4:0]  r_cnt;

    logic [15:0] r_damp;

    logic [63:0] r_prod;      // multiplier output, also dividend/quotient
    logic [63:0] r_sq;        // sum of squares, shifted out by the root
    logic [32:0] r_rem;       // root remainder
    logic [31:0] r_root;      // length once the root is done
    logic [31:0] r_dfmag;     // |rest - length|
    logic        r_dfneg;
    logic [63:0] r_spring;

    logic signed [VALUE_WIDTH-1:0] r_acc [3];
    logic                          r_flag;

    logic [95:0] r_out_data;
    logic        r_out_user;
    logic        r_out_valid;

    // Shared multiplier and subtractor
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic [34:0] sub_a, sub_b;
    logic [35:0] sub_d;
    logic        len_zero;

    assign mul_p    = mul_a * mul_b;
    assign sub_d    = {1'b0, sub_a} - {1'b0, sub_b};
    assign len_zero = (r_root == 32'd0);

    // Input field unpacking
    logic signed [31:0] in_d [3];
    logic signed [31:0] in_v [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            in_d[i] = s_axis_tdata[32*i +: 32];
            in_v[i] = s_axis_tdata[96 + 32*i +: 32];
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dsfa_pkg::ST_IDLE: begin
                if (s_axis_tvalid) n_state = dsfa_pkg::ST_SQ;
            end
            dsfa_pkg::ST_SQ:     n_state = dsfa_pkg::ST_SQ_ACC;
            dsfa_pkg::ST_SQ_ACC: begin
                n_state = (r_axis == 2'd2) ? dsfa_pkg::ST_ROOT : dsfa_pkg::ST_SQ;
            end
            dsfa_pkg::ST_ROOT: begin
                if (r_cnt == 5'd31) n_state = dsfa_pkg::ST_DIFF;
            end
            dsfa_pkg::ST_DIFF: begin
                n_state = len_zero ? dsfa_pkg::ST_MUL_DAMP : dsfa_pkg::ST_MUL_DIFF;
            end
            dsfa_pkg::ST_MUL_DIFF: n_state = dsfa_pkg::ST_DIV;
            dsfa_pkg::ST_DIV: begin
                if (r_cnt == 5'd31) n_state = dsfa_pkg::ST_MUL_K;
            end
            dsfa_pkg::ST_MUL_K:    n_state = dsfa_pkg::ST_MUL_DAMP;
            dsfa_pkg::ST_MUL_DAMP: n_state = dsfa_pkg::ST_ACC;
            dsfa_pkg::ST_ACC: begin
                if (r_axis == 2'd2)
                    n_state = r_last ? dsfa_pkg::ST_EMIT : dsfa_pkg::ST_IDLE;
                else
                    n_state = len_zero ? dsfa_pkg::ST_MUL_DAMP : dsfa_pkg::ST_MUL_DIFF;
            end
            dsfa_pkg::ST_EMIT: begin
                if (!r_out_valid || m_axis_tready) n_state = dsfa_pkg::ST_IDLE;
            end
            default: n_state = dsfa_pkg::ST_IDLE;
        endcase
    end

    // Unit operand selection and handshake outputs
    always_comb begin
        s_axis_tready = 1'b0;
        mul_a         = 32'd0;
        mul_b         = 32'd0;
        sub_a         = {r_rem, r_sq[63:62]};
        sub_b         = {1'b0, r_root, 2'b01};
        unique case (r_state)
            dsfa_pkg::ST_IDLE: s_axis_tready = 1'b1;
            dsfa_pkg::ST_SQ: begin
                mul_a = r_dmag[r_axis];
                mul_b = r_dmag[r_axis];
            end
            dsfa_pkg::ST_MUL_DIFF: begin
                mul_a = r_dfmag;
                mul_b = r_dmag[r_axis];
            end
            dsfa_pkg::ST_DIV: begin
                sub_a = {2'b00, r_prod[63:31]};
                sub_b = {3'b000, r_root};
            end
            dsfa_pkg::ST_MUL_K: begin
                mul_a = r_prod[31:0];
                mul_b = {1'b0, r_k};
            end
            dsfa_pkg::ST_MUL_DAMP: begin
                mul_a = r_vmag[r_axis];
                mul_b = {16'd0, r_damp};
            end
            default: ;
        endcase
    end

    // Per-axis force and saturating accumulate
    logic signed [FW-1:0]          spr_s, dmp_s, force_w;
    logic signed [VALUE_WIDTH-1:0] force_sat;
    logic signed [VALUE_WIDTH:0]   acc_sum;
    logic signed [VALUE_WIDTH-1:0] acc_new;
    logic [63:0]                   dmp_mag;
    always_comb begin
        dmp_mag = r_prod >> FRAC_BITS;
        spr_s   = (r_dfneg ^ r_dneg[r_axis]) ? -$signed({2'b00, r_spring})
                                             :  $signed({2'b00, r_spring});
        dmp_s   = r_vneg[r_axis] ? -$signed({2'b00, dmp_mag})
                                 :  $signed({2'b00, dmp_mag});
        force_w = spr_s - dmp_s;
        if (force_w > F_HI)      force_sat = F_HI[VALUE_WIDTH-1:0];
        else if (force_w < F_LO) force_sat = F_LO[VALUE_WIDTH-1:0];
        else                     force_sat = force_w[VALUE_WIDTH-1:0];
        acc_sum = {r_acc[r_axis][VALUE_WIDTH-1], r_acc[r_axis]}
                + {force_sat[VALUE_WIDTH-1], force_sat};
        if (acc_sum[VALUE_WIDTH] != acc_sum[VALUE_WIDTH-1])
            acc_new = acc_sum[VALUE_WIDTH] ? F_LO[VALUE_WIDTH-1:0]
                                           : F_HI[VALUE_WIDTH-1:0];
        else
            acc_new = acc_sum[VALUE_WIDTH-1:0];
    end

    // Totals clamped to the 32-bit output range
    logic [95:0] out_sat;
    always_comb begin
        logic signed [FW-1:0] e;
        for (int i = 0; i < 3; i++) begin
            e = FW'(r_acc[i]);
            if (e > O_HI)      out_sat[32*i +: 32] = O_HI[31:0];
            else if (e < O_LO) out_sat[32*i +: 32] = O_LO[31:0];
            else               out_sat[32*i +: 32] = e[31:0];
        end
    end

    logic [32:0] diff_w;
    assign diff_w = {2'b00, r_rest} - {1'b0, r_root};

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dsfa_pkg::ST_IDLE;
            r_damp      <= dsfa_pkg::DAMPING_RESET;
            r_flag      <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 3; i++) r_acc[i] <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) r_damp <= i_cfg_data;
            if (r_state == dsfa_pkg::ST_DIFF && len_zero) r_flag <= 1'b1;
            if (r_state == dsfa_pkg::ST_ACC) r_acc[r_axis] <= acc_new;
            if (r_state == dsfa_pkg::ST_EMIT && (!r_out_valid || m_axis_tready)) begin
                r_out_valid <= 1'b1;
                r_flag      <= 1'b0;
                for (int i = 0; i < 3; i++) r_acc[i] <= '0;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            dsfa_pkg::ST_IDLE: begin
                for (int i = 0; i < 3; i++) begin
                    r_dmag[i] <= in_d[i][31] ? 32'(-in_d[i]) : in_d[i];
                    r_dneg[i] <= in_d[i][31];
                    r_vmag[i] <= in_v[i][31] ? 32'(-in_v[i]) : in_v[i];
                    r_vneg[i] <= in_v[i][31];
                end
                r_rest <= s_axis_tdata[222:192];
                r_k    <= s_axis_tdata[253:223];
                r_last <= s_axis_tlast;
                r_axis <= 2'd0;
                r_sq   <= 64'd0;
            end
            dsfa_pkg::ST_SQ: r_prod <= mul_p;
            dsfa_pkg::ST_SQ_ACC: begin
                r_sq   <= r_sq + r_prod;
                r_axis <= r_axis + 2'd1;
                r_cnt  <= 5'd0;
                r_rem  <= 33'd0;
                r_root <= 32'd0;
            end
            dsfa_pkg::ST_ROOT: begin
                if (!sub_d[35]) begin
                    r_rem  <= sub_d[32:0];
                    r_root <= {r_root[30:0], 1'b1};
                end else begin
                    r_rem  <= sub_a[32:0];
                    r_root <= {r_root[30:0], 1'b0};
                end
                r_sq  <= {r_sq[61:0], 2'b00};
                r_cnt <= r_cnt + 5'd1;
            end
            dsfa_pkg::ST_DIFF: begin
                r_dfneg  <= diff_w[32];
                r_dfmag  <= diff_w[32] ? 32'(-diff_w) : diff_w[31:0];
                r_axis   <= 2'd0;
                r_spring <= 64'd0;
            end
            dsfa_pkg::ST_MUL_DIFF: begin
                r_prod <= mul_p;
                r_cnt  <= 5'd0;
            end
            dsfa_pkg::ST_DIV: begin
                if (!sub_d[35]) r_prod <= {sub_d[31:0], r_prod[30:0], 1'b1};
                else            r_prod <= {r_prod[62:0], 1'b0};
                r_cnt <= r_cnt + 5'd1;
            end
            dsfa_pkg::ST_MUL_K: r_prod <= mul_p;
            dsfa_pkg::ST_MUL_DAMP: begin
                r_spring <= len_zero ? 64'd0 : (r_prod >> FRAC_BITS);
                r_prod   <= mul_p;
            end
            dsfa_pkg::ST_ACC: begin
                if (r_axis != 2'd2) r_axis <= r_axis + 2'd1;
            end
            dsfa_pkg::ST_EMIT: begin
                if (!r_out_valid || m_axis_tready) begin
                    r_out_data <= out_sat;
                    r_out_user <= r_flag;
                end
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;
    assign o_cfg_ready   = 1'b1;

endmodule

// ----- tb/sv/damped_spring_force_accumulator_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// damped_spring_force_accumulator_test: self-checking bench of the force block
// Streams spring connections through the block in several damping settings
// and compares every summed force request against an in-bench predictor.
// ----------------------------------------------------------------------------
module damped_spring_force_accumulator_test;

    localparam int FRAC       = dsfa_pkg::FRAC_BITS_DEF;
    localparam int DRAIN_CYC  = 300;     // > one request through the sequencer
    localparam int HOLD_CYC   = 1500;    // long receiver hold-off
    localparam int WDOG_LIMIT = 20000;   // cycles without any handshake

    typedef struct {
        logic [2:0][31:0] pos;
        logic [2:0][31:0] vel;
        logic [30:0]      rest;
        logic [30:0]      stiff;
        logic [1:0]       pad;
        logic             last;
    } conn_t;

    typedef struct {
        logic [2:0][31:0] force_v;
        logic             zero_len;
    } force_t;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [255:0] s_axis_tdata;
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [95:0]  m_axis_tdata;
    logic         m_axis_tuser;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [15:0]  i_cfg_data;

    damped_spring_force_accumulator u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    conn_t       pending_conns[$];
    force_t      expected_forces[$];
    conn_t       conn_on_bus;
    longint      acc_force[3];
    logic        acc_zero_len;
    logic [15:0] damping_model;
    int          n_conns;
    int          n_forces;
    int          n_errors;
    int          n_zero_len;
    int          hold_cnt;
    logic        hold_done;
    logic        no_idle;

    // no-idle stretch on both sides, somewhere mid-run
    assign no_idle = (n_conns >= 300) && (n_conns < 400);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------- predictor ----------------
    function automatic logic [63:0] mag64(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 64'd0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint sat32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // One axis: spring term on magnitudes (products wrap at 64 bits),
    // truncated toward zero, minus the damping term.
    function automatic longint axis_force(input longint diff, input longint d,
                                          input longint v, input logic [63:0] len,
                                          input logic [63:0] k);
        logic [63:0] q;
        logic [63:0] s;
        logic [63:0] dm;
        longint      spring;
        longint      damp;
        spring = 0;
        if (len != 0) begin
            q = (mag64(diff) * mag64(d)) / len;
            s = (q * k) >> FRAC;
            spring = ((diff < 0) != (d < 0)) ? -$signed(s) : $signed(s);
        end
        dm = (mag64(v) * {48'd0, damping_model}) >> FRAC;
        damp = (v < 0) ? -$signed(dm) : $signed(dm);
        return sat32(spring - damp);
    endfunction

    task automatic predict_connection(input conn_t c);
        logic [63:0] sq;
        logic [63:0] len;
        longint      diff;
        longint      dv[3];
        force_t      f;
        sq = 64'd0;
        for (int a = 0; a < 3; a++) begin
            dv[a] = $signed(c.pos[a]);
            sq = sq + mag64(dv[a]) * mag64(dv[a]);
        end
        len = floor_sqrt(sq);
        diff = $signed({33'd0, c.rest}) - $signed(len);
        if (len == 0) acc_zero_len = 1'b1;
        for (int a = 0; a < 3; a++)
            acc_force[a] = sat32(acc_force[a] + axis_force(diff, dv[a],
                                 $signed(c.vel[a]), len, {33'd0, c.stiff}));
        if (c.last) begin
            for (int a = 0; a < 3; a++) begin
                f.force_v[a] = acc_force[a][31:0];
                acc_force[a] = 0;
            end
            f.zero_len = acc_zero_len;
            if (acc_zero_len) n_zero_len++;
            acc_zero_len = 1'b0;
            expected_forces = {expected_forces, f};
        end
    endtask

    // ---------------- driver ----------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tlast  <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_connection(conn_on_bus);
                n_conns <= n_conns + 1;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_conns.size() != 0 &&
                        (no_idle || $urandom_range(99) >= 33)) begin
                    conn_on_bus = pending_conns.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {conn_on_bus.pad, conn_on_bus.stiff,
                                      conn_on_bus.rest, conn_on_bus.vel,
                                      conn_on_bus.pos};
                    s_axis_tlast  <= conn_on_bus.last;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------- monitor / receiver ----------------
    always @(posedge i_clk) begin
        force_t e;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            hold_cnt      <= 0;
            hold_done     <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                n_forces <= n_forces + 1;
                if (expected_forces.size() == 0) begin
                    $display("%0t: unexpected force request %h tuser %b",
                             $time, m_axis_tdata, m_axis_tuser);
                    n_errors++;
                end else begin
                    e = expected_forces.pop_front();
                    for (int a = 0; a < 3; a++)
                        if (m_axis_tdata[32*a +: 32] !== e.force_v[a]) begin
                            $display("%0t: force axis %0d expected %h actual %h",
                                     $time, a, e.force_v[a], m_axis_tdata[32*a +: 32]);
                            n_errors++;
                        end
                    if (m_axis_tuser !== e.zero_len) begin
                        $display("%0t: zero_length_seen expected %b actual %b",
                                 $time, e.zero_len, m_axis_tuser);
                        n_errors++;
                    end
                end
            end
            // one long hold-off so the block backs up and stalls its input
            if (!hold_done && n_conns == 100) begin
                hold_cnt      <= HOLD_CYC;
                hold_done     <= 1'b1;
                m_axis_tready <= 1'b0;
            end else if (hold_cnt != 0) begin
                hold_cnt      <= hold_cnt - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= no_idle || ($urandom_range(99) >= 33);
            end
        end
    end

    // ---------------- watchdog ----------------
    always @(posedge i_clk) begin
        int quiet;
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
                (m_axis_tvalid && m_axis_tready) || (i_cfg_valid && o_cfg_ready)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= WDOG_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, quiet);
                $display("FAIL damped_spring_force_accumulator");
                $finish;
            end
        end
    end

    // ---------------- stimulus ----------------
    function automatic logic [31:0] rand_val(input int mode);
        logic [31:0] m;
        case (mode)
            0:       return $urandom;
            1:       m = $urandom_range(32'h000FFFFF);
            2:       m = $urandom_range(32'h00FFFFFF);
            default: m = $urandom_range(32'h0003FFFF);
        endcase
        return $urandom_range(1) ? -m : m;
    endfunction

    task automatic push_conn(input logic [31:0] px, py, pz, vx, vy, vz,
                             input logic [30:0] rest, stiff, input logic last);
        conn_t c;
        c.pos   = {pz, py, px};
        c.vel   = {vz, vy, vx};
        c.rest  = rest;
        c.stiff = stiff;
        c.pad   = 2'($urandom_range(3));
        c.last  = last;
        pending_conns = {pending_conns, c};
    endtask

    task automatic push_random_runs(input int count);
        int mode;
        int run_len;
        conn_t c;
        int n;
        n = 0;
        while (n < count) begin
            run_len = $urandom_range(6, 1);
            for (int i = 0; i < run_len; i++) begin
                mode = $urandom_range(3);
                for (int a = 0; a < 3; a++) begin
                    c.pos[a] = rand_val(mode);
                    c.vel[a] = rand_val($urandom_range(3));
                end
                if ($urandom_range(19) == 0) c.pos = '0;
                c.rest  = (mode == 0) ? 31'($urandom)
                                      : 31'(rand_val(mode) & 32'h00FFFFFF);
                c.stiff = $urandom_range(1) ? 31'($urandom)
                                            : 31'($urandom_range(32'h3FFFF));
                c.pad   = 2'($urandom_range(3));
                c.last  = (i == run_len - 1);
                pending_conns = {pending_conns, c};
            end
            n += run_len;
        end
    endtask

    // sender pauses here until every summed force has come back;
    // sampled at the falling edge so the driver's updates have settled
    task automatic wait_drained;
        while (pending_conns.size() != 0 || s_axis_tvalid) @(negedge i_clk);
        while (expected_forces.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic write_damping(input logic [15:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid   <= 1'b0;
        damping_model = value;
    endtask

    initial begin
        logic [15:0] damp_set[4];
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        i_rst_n       = 1'b0;
        n_conns = 0; n_forces = 0; n_errors = 0; n_zero_len = 0;
        acc_force = '{0, 0, 0};
        acc_zero_len  = 1'b0;
        damping_model = dsfa_pkg::DAMPING_RESET;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset damping value
        // zero length: damping part only, flag set
        push_conn(0, 0, 0, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 31'h7FFFFFFF,
                  31'h7FFFFFFF, 1);
        push_conn(0, 0, 0, 0, 0, 0, 0, 0, 1);
        // extremes of position, rest and stiffness
        push_conn(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                  32'h80000000, 32'h80000000, 31'h7FFFFFFF, 31'h7FFFFFFF, 1);
        push_conn(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                  32'h7FFFFFFF, 32'h7FFFFFFF, 0, 31'h7FFFFFFF, 1);
        push_conn(32'hFFFFFFFF, 1, 0, 1, 32'hFFFFFFFF, 0, 31'h00010000, 31'h00010000, 1);
        // run of several connections, one degenerate mid-run
        push_conn(32'h00010000, 0, 0, 32'h00008000, 0, 0, 31'h00020000, 31'h00050000, 0);
        push_conn(0, 0, 0, 0, 32'h00010000, 0, 31'h00010000, 31'h00010000, 0);
        push_conn(0, 32'hFFFE0000, 32'h00030000, 0, 0, 32'hFFFF0000, 31'h00010000,
                  31'h00020000, 1);
        // flag cleared after emit
        push_conn(32'h00030000, 32'h00040000, 0, 0, 0, 0, 31'h00050000, 31'h00010000, 1);
        // accumulator saturation, both signs
        repeat (3) push_conn(32'h00000001, 0, 0, 32'h80000000, 32'h7FFFFFFF, 0,
                             31'h7FFFFFFF, 31'h7FFFFFFF, 0);
        push_conn(32'hFFFFFFFF, 32'hFFFFFFFF, 1, 32'h80000000, 0, 0, 31'h7FFFFFFF,
                  31'h7FFFFFFF, 1);
        push_conn(0, 0, 32'h40000000, 0, 0, 0, 31'h00000001, 31'h7FFFFFFF, 1);
        push_random_runs(160);
        wait_drained();

        damp_set = '{16'd0, 16'hFFFF, 16'h0000, dsfa_pkg::DAMPING_RESET};
        damp_set[2] = 16'($urandom);
        for (int p = 0; p < 4; p++) begin
            write_damping(damp_set[p]);
            push_conn(0, 0, 0, 32'h80000000, 32'h7FFFFFFF, 32'h00010000, 0, 0, 1);
            push_random_runs(p == 3 ? 130 : 120);
            wait_drained();
        end

        $display("Covered %0d connections in %0d summed forces, %0d with a zero length,",
                 n_conns, n_forces, n_zero_len);
        $display("over five damping settings including both extremes.");
        if (n_errors == 0 && expected_forces.size() == 0) begin
            $display("PASS damped_spring_force_accumulator");
        end else begin
            $display("FAIL damped_spring_force_accumulator");
        end
        $finish;
    end

endmodule
